/* rtl/huffman_tree_decoder_macros.svh */
// ---------------------------------------------------------------------------
// huffman tree decoder assertion macros
// Shared concurrent assertion forms, all disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_MACROS_SVH
`define HUFFMAN_TREE_DECODER_MACROS_SVH

// plain property check, clocked on the rising edge
`define HTD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// overlapping implication check
`define HTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/htd_pkg.sv */
// ---------------------------------------------------------------------------
// htd_pkg
// Command and status codes, field widths and the result record of the
// huffman tree decoder.
// ---------------------------------------------------------------------------
package htd_pkg;

  localparam int unsigned SymW      = 8;
  localparam int unsigned CodeBitsW = 16;
  localparam int unsigned CodeLenW  = 5;

  // input commands
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // one result record
  typedef struct packed {
    logic            sym_valid;
    logic [SymW-1:0] sym;
    status_e         status;
  } res_t;

endpackage

/* rtl/htd_node_mem.sv */
// ---------------------------------------------------------------------------
// htd_node_mem
// Node table: one write port, one read port with registered read data.
// The root entry reads as cleared until it is first written after reset
// or after a table clear.
// ---------------------------------------------------------------------------
module htd_node_mem #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned WIDTH  = 27,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic             root_vld_q;
  logic             root_zero_q;

  // storage array, synchronous write and read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // root valid tracking, so no clearing pass is needed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_vld_q  <= 1'b0;
      root_zero_q <= 1'b0;
    end else begin
      if (clr_i) begin
        root_vld_q <= 1'b0;
      end else if (wr_en_i && (wr_addr_i == '0)) begin
        root_vld_q <= 1'b1;
      end
      if (rd_en_i) begin
        root_zero_q <= (rd_addr_i == '0) && !root_vld_q;
      end
    end
  end

  assign rd_data_o = root_zero_q ? '0 : rdata_q;

endmodule

/* rtl/htd_res_q.sv */
// ---------------------------------------------------------------------------
// htd_res_q
// Two-entry result queue: output register plus skid register, so a new
// item can be taken while a finished result waits for its transfer.
// ---------------------------------------------------------------------------
`include "huffman_tree_decoder_macros.svh"

module htd_res_q (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  htd_pkg::res_t res_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output htd_pkg::res_t out_res_o
);

  logic          out_vld_q, out_vld_d;
  logic          skid_vld_q, skid_vld_d;
  htd_pkg::res_t out_q, out_d;
  htd_pkg::res_t skid_q, skid_d;
  logic          pop;

  assign pop = out_vld_q && out_ready_i;

  // shift on transfer, then place the new result in the first free slot
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop) begin
      out_vld_d  = skid_vld_q;
      out_d      = skid_q;
      skid_vld_d = 1'b0;
    end
    if (push_i) begin
      if (!out_vld_d) begin
        out_vld_d = 1'b1;
        out_d     = res_i;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = res_i;
      end
    end
  end

  // slot valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // slot payloads
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  // skid slot only ever holds the younger of two results
  `HTD_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_vld_q |-> out_vld_q, "skid full with output empty")
  // one item in flight, so a push never meets a full queue
  `HTD_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, push_i, !skid_vld_q, "result pushed into full queue")

endmodule

/* rtl/htd_ctrl.sv */
// ---------------------------------------------------------------------------
// htd_ctrl
// Sequencer for insert, decode and clear. Walks the node table through the
// memory read port, allocates nodes and writes entries back.
// ---------------------------------------------------------------------------
`include "huffman_tree_decoder_macros.svh"

module htd_ctrl #(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned MAX_NODES    = 512,
  parameter int unsigned IDX_W        = $clog2(MAX_NODES),
  parameter int unsigned ENT_W        = 2 * IDX_W + htd_pkg::SymW + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [htd_pkg::SymW-1:0]      symbol_in_i,
  input  logic [htd_pkg::CodeBitsW-1:0] code_bits_i,
  input  logic [htd_pkg::CodeLenW-1:0]  code_len_i,
  input  logic                          code_bit_i,
  input  logic                          q_full_i,
  output logic                          res_push_o,
  output htd_pkg::res_t                 res_o,
  output logic                          mem_clr_o,
  output logic                          mem_rd_en_o,
  output logic [IDX_W-1:0]              mem_rd_addr_o,
  input  logic [ENT_W-1:0]              mem_rd_data_i,
  output logic                          mem_wr_en_o,
  output logic [IDX_W-1:0]              mem_wr_addr_o,
  output logic [ENT_W-1:0]              mem_wr_data_o
);

  localparam int unsigned CntW = $clog2(MAX_NODES + 1);
  localparam int unsigned LenW = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned SymW = htd_pkg::SymW;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_INS      = 4'b0010,
    S_DEC_NODE = 4'b0100,
    S_DEC_LEAF = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         nodes_used_q, nodes_used_d;
  logic [IDX_W-1:0]        dec_node_q, dec_node_d;
  logic                    hit_q, hit_d;
  logic [IDX_W-1:0]        cur_q, cur_d;
  logic                    fresh_q, fresh_d;
  logic [LenW-1:0]         cnt_q, cnt_d;
  logic [MAX_CODE_LEN-1:0] bits_q, bits_d;
  logic [SymW-1:0]         sym_q, sym_d;
  logic                    bit_q, bit_d;
  logic [IDX_W-1:0]        nxt_q, nxt_d;

  htd_pkg::cmd_e                              cmd;
  logic                                       in_fire;
  logic [LenW-1:0]                            len_eff;
  logic [MAX_CODE_LEN+htd_pkg::CodeBitsW-1:0] bits_ext;
  logic [ENT_W-1:0]                           ins_ent;
  logic [IDX_W-1:0]                           ins_left, ins_right, ins_slot;
  logic [SymW-1:0]                            ins_sym;
  logic                                       ins_leaf;
  logic [MAX_CODE_LEN-1:0]                    ins_sh;
  logic                                       ins_bit;
  logic [IDX_W-1:0]                           new_idx;
  logic [IDX_W-1:0]                           rd_left, rd_right, dec_nxt;
  logic [SymW-1:0]                            rd_sym;
  logic                                       rd_leaf;
  logic                                       step_bit;
  logic                                       dec_step;

  assign cmd        = htd_pkg::cmd_e'(cmd_i);
  assign in_ready_o = (state_q == S_IDLE) && !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // codeword length clipped to the supported maximum
  always_comb begin
    if (32'(code_len_i) > MAX_CODE_LEN) begin
      len_eff = LenW'(MAX_CODE_LEN);
    end else begin
      len_eff = LenW'(code_len_i);
    end
  end

  assign bits_ext = {{MAX_CODE_LEN{1'b0}}, code_bits_i};

  // insert walk: current entry, known cleared when freshly allocated
  assign ins_ent   = fresh_q ? '0 : mem_rd_data_i;
  assign ins_left  = ins_ent[IDX_W-1:0];
  assign ins_right = ins_ent[2*IDX_W-1:IDX_W];
  assign ins_sym   = ins_ent[2*IDX_W+SymW-1:2*IDX_W];
  assign ins_leaf  = ins_ent[ENT_W-1];
  assign ins_sh    = bits_q >> (cnt_q - LenW'(1));
  assign ins_bit   = ins_sh[0];
  assign ins_slot  = ins_bit ? ins_right : ins_left;
  assign new_idx   = nodes_used_q[IDX_W-1:0];

  // decode: entry in the read register
  assign rd_left  = mem_rd_data_i[IDX_W-1:0];
  assign rd_right = mem_rd_data_i[2*IDX_W-1:IDX_W];
  assign rd_sym   = mem_rd_data_i[2*IDX_W+SymW-1:2*IDX_W];
  assign rd_leaf  = mem_rd_data_i[ENT_W-1];
  assign step_bit = (state_q == S_IDLE) ? code_bit_i : bit_q;
  assign dec_nxt  = step_bit ? rd_right : rd_left;

  // sequencer
  always_comb begin
    state_d       = state_q;
    nodes_used_d  = nodes_used_q;
    dec_node_d    = dec_node_q;
    hit_d         = hit_q;
    cur_d         = cur_q;
    fresh_d       = fresh_q;
    cnt_d         = cnt_q;
    bits_d        = bits_q;
    sym_d         = sym_q;
    bit_d         = bit_q;
    nxt_d         = nxt_q;
    mem_clr_o     = 1'b0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = '0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = '0;
    mem_wr_data_o = '0;
    res_push_o    = 1'b0;
    res_o         = '0;
    res_o.status  = htd_pkg::ST_OK;
    dec_step      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          bit_d   = code_bit_i;
          sym_d   = symbol_in_i;
          bits_d  = bits_ext[MAX_CODE_LEN-1:0];
          cur_d   = '0;
          fresh_d = 1'b0;
          cnt_d   = len_eff;
          unique case (cmd)
            htd_pkg::CMD_INSERT: begin
              hit_d = 1'b0;
              if (len_eff == '0) begin
                res_push_o = 1'b1;
              end else begin
                mem_rd_en_o = 1'b1;
                state_d     = S_INS;
              end
            end
            htd_pkg::CMD_DECODE: begin
              if (hit_q) begin
                dec_step = 1'b1;
              end else begin
                mem_rd_en_o   = 1'b1;
                mem_rd_addr_o = dec_node_q;
                state_d       = S_DEC_NODE;
              end
            end
            htd_pkg::CMD_CLEAR: begin
              mem_clr_o    = 1'b1;
              nodes_used_d = CntW'(1);
              dec_node_d   = '0;
              hit_d        = 1'b0;
              res_push_o   = 1'b1;
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        priority if (cnt_q == '0) begin
          // last node: mark it as a leaf unless it already is one
          if (ins_leaf) begin
            res_o.status = htd_pkg::ST_DUP;
            dec_node_d   = '0;
          end else begin
            mem_wr_en_o   = 1'b1;
            mem_wr_addr_o = cur_q;
            mem_wr_data_o = {1'b1, sym_q, ins_right, ins_left};
          end
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end else if (ins_slot != '0) begin
          // child exists, follow it
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = ins_slot;
          cur_d         = ins_slot;
          fresh_d       = 1'b0;
          cnt_d         = cnt_q - LenW'(1);
        end else if (nodes_used_q == CntW'(MAX_NODES)) begin
          // table full: a fresh node still has to land cleared
          if (fresh_q) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_addr_o = cur_q;
          end
          res_o.status = htd_pkg::ST_FULL;
          res_push_o   = 1'b1;
          dec_node_d   = '0;
          state_d      = S_IDLE;
        end else begin
          // allocate a child and link it into the current node
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = cur_q;
          mem_wr_data_o = ins_bit ? {ins_leaf, ins_sym, new_idx, ins_left}
                                  : {ins_leaf, ins_sym, ins_right, new_idx};
          cur_d         = new_idx;
          fresh_d       = 1'b1;
          nodes_used_d  = nodes_used_q + CntW'(1);
          cnt_d         = cnt_q - LenW'(1);
        end
      end

      S_DEC_NODE: begin
        dec_step = 1'b1;
      end

      S_DEC_LEAF: begin
        if (rd_leaf) begin
          // symbol found, back to the root and prefetch it
          res_o.sym_valid = 1'b1;
          res_o.sym       = rd_sym;
          dec_node_d      = '0;
          mem_rd_en_o     = 1'b1;
        end else begin
          dec_node_d = nxt_q;
        end
        hit_d      = 1'b1;
        res_push_o = 1'b1;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // one decode step on the entry held in the read register
    if (dec_step) begin
      if (dec_nxt == '0) begin
        res_o.status = htd_pkg::ST_MISSING;
        res_push_o   = 1'b1;
        dec_node_d   = '0;
        mem_rd_en_o  = 1'b1;
        hit_d        = 1'b1;
        state_d      = S_IDLE;
      end else begin
        nxt_d         = dec_nxt;
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = dec_nxt;
        hit_d         = 1'b0;
        state_d       = S_DEC_LEAF;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      nodes_used_q <= CntW'(1);
      dec_node_q   <= '0;
      hit_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      nodes_used_q <= nodes_used_d;
      dec_node_q   <= dec_node_d;
      hit_q        <= hit_d;
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    fresh_q <= fresh_d;
    cnt_q   <= cnt_d;
    bits_q  <= bits_d;
    sym_q   <= sym_d;
    bit_q   <= bit_d;
    nxt_q   <= nxt_d;
  end

  // read and write never meet on one entry, so no forwarding path exists
  `HTD_ASSERT_IMP(a_no_rw_clash, clk_i, rst_ni, mem_rd_en_o && mem_wr_en_o, mem_rd_addr_o != mem_wr_addr_o, "node read and write on the same entry")
  // node count moves by one allocation or back to root only
  `HTD_ASSERT_IMP(a_alloc_step, clk_i, rst_ni, nodes_used_q != $past(nodes_used_q), (nodes_used_q == $past(nodes_used_q) + 1'b1) || (nodes_used_q == CntW'(1)), "node count jumped")
  // an insert walk overwrites the read register
  `HTD_ASSERT_IMP(a_no_hit_in_insert, clk_i, rst_ni, state_q == S_INS, !hit_q, "decode entry marked held during insert")

endmodule

/* rtl/huffman_tree_decoder.sv */
// ---------------------------------------------------------------------------
// huffman_tree_decoder
// Bit-serial huffman decoder over a node table held in one memory.
// ---------------------------------------------------------------------------
// Each input transfer carries one command. A decode bit goes from idle
// straight to the child read when the current node's entry is still in the
// table read register (after a decode step, a decoded symbol or a missing
// child), and passes through a node fetch first when it has to be fetched
// (first decode after reset, an insert or a clear). An insert walks the
// codeword, code_len clipped to MAX_CODE_LEN, with one table read or write
// per codeword bit plus the leaf write; it stops early when the table runs
// full. Clear, the unused command and an empty codeword push their result
// in the cycle they are accepted. Every command gives one result; up to
// two results queue at the output, so a new command is taken while a
// result waits. After reset and after a clear the table is usable at once:
// there is no clearing pass.
// ---------------------------------------------------------------------------
module huffman_tree_decoder #(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned MAX_NODES    = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [htd_pkg::SymW-1:0]      symbol_in_i,
  input  logic [htd_pkg::CodeBitsW-1:0] code_bits_i,
  input  logic [htd_pkg::CodeLenW-1:0]  code_len_i,
  input  logic                          code_bit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          symbol_valid_o,
  output logic [htd_pkg::SymW-1:0]      symbol_out_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned IdxW = $clog2(MAX_NODES);
  localparam int unsigned EntW = 2 * IdxW + htd_pkg::SymW + 1;

  logic            q_full;
  logic            res_push;
  htd_pkg::res_t   res;
  htd_pkg::res_t   out_res;
  logic            mem_clr;
  logic            mem_rd_en;
  logic [IdxW-1:0] mem_rd_addr;
  logic [EntW-1:0] mem_rd_data;
  logic            mem_wr_en;
  logic [IdxW-1:0] mem_wr_addr;
  logic [EntW-1:0] mem_wr_data;

  // command sequencer
  htd_ctrl #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .MAX_NODES    (MAX_NODES),
    .IDX_W        (IdxW),
    .ENT_W        (EntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .symbol_in_i   (symbol_in_i),
    .code_bits_i   (code_bits_i),
    .code_len_i    (code_len_i),
    .code_bit_i    (code_bit_i),
    .q_full_i      (q_full),
    .res_push_o    (res_push),
    .res_o         (res),
    .mem_clr_o     (mem_clr),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data)
  );

  // node table
  htd_node_mem #(
    .DEPTH  (MAX_NODES),
    .WIDTH  (EntW),
    .ADDR_W (IdxW)
  ) u_node_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (mem_clr),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  // result queue
  htd_res_q u_res_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .res_i       (res),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign symbol_valid_o = out_res.sym_valid;
  assign symbol_out_o   = out_res.sym;
  assign status_o       = out_res.status;

endmodule

/* test/huffman_tree_decoder_tb.sv */
// ---------------------------------------------------------------------------
// huffman_tree_decoder_tb
// Self-checking bench for the bit-serial huffman decoder. A short table of
// directed commands covers the corner cases, then random phases build code
// tables, walk their codewords bit by bit with some noise, and now and then
// fill the node table to overflow. Results are checked against an in-bench
// node table model or typed values, with random idling on both channels.
// ---------------------------------------------------------------------------
module huffman_tree_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_CODE_LEN = 16;
  localparam int unsigned MAX_NODES    = 512;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned END_SETTLE   = 40;
  localparam int unsigned PRINT_CAP    = 50;

  typedef struct {
    htd_pkg::cmd_e cmd;
    logic [7:0]    sym;
    logic [15:0]   bits;
    logic [4:0]    len;
    logic          bit_v;
    bit            typed;
    htd_pkg::res_t want;
  } stim_row_t;

  typedef struct {
    logic [15:0] bits;
    logic [4:0]  len;
  } codeword_t;

  localparam htd_pkg::res_t R_OK   = '{1'b0, 8'h00, htd_pkg::ST_OK};
  localparam htd_pkg::res_t R_DUP  = '{1'b0, 8'h00, htd_pkg::ST_DUP};
  localparam htd_pkg::res_t R_MISS = '{1'b0, 8'h00, htd_pkg::ST_MISSING};

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [1:0]                    cmd_i;
  logic [htd_pkg::SymW-1:0]      symbol_in_i;
  logic [htd_pkg::CodeBitsW-1:0] code_bits_i;
  logic [htd_pkg::CodeLenW-1:0]  code_len_i;
  logic                          code_bit_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          symbol_valid_o;
  logic [htd_pkg::SymW-1:0]      symbol_out_o;
  logic [1:0]                    status_o;

  // model of the node table
  int unsigned tree_left  [MAX_NODES];
  int unsigned tree_right [MAX_NODES];
  logic [7:0]  tree_sym   [MAX_NODES];
  bit          tree_leaf  [MAX_NODES];
  int unsigned tree_used;
  int unsigned walk_node;

  htd_pkg::res_t due_results[$];
  codeword_t     known_codes[$];
  bit            steady;
  int unsigned   mismatches;
  int unsigned   n_items;
  int unsigned   n_symbols;
  int unsigned   n_dup;
  int unsigned   n_full;
  int unsigned   n_missing;
  int unsigned   idle_cycles;

  // directed commands, expectations typed only where obvious
  stim_row_t directed [25] = '{
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, R_MISS},
    '{htd_pkg::CMD_NOP,    8'hFF, 16'hFFFF, 5'd31, 1'b1, 1'b1, R_OK},
    '{htd_pkg::CMD_INSERT, 8'hFF, 16'hFFFF, 5'd0,  1'b1, 1'b1, R_OK},
    '{htd_pkg::CMD_INSERT, 8'hA5, 16'h0000, 5'd1,  1'b0, 1'b1, R_OK},
    '{htd_pkg::CMD_INSERT, 8'h5A, 16'h0002, 5'd2,  1'b0, 1'b1, R_OK},
    '{htd_pkg::CMD_INSERT, 8'h3C, 16'h0003, 5'd2,  1'b0, 1'b1, R_OK},
    '{htd_pkg::CMD_INSERT, 8'h00, 16'h0000, 5'd1,  1'b0, 1'b1, R_DUP},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1,
      '{1'b1, 8'hA5, htd_pkg::ST_OK}},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b1, R_OK},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b1,
      '{1'b1, 8'h3C, htd_pkg::ST_OK}},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, R_OK},
    '{htd_pkg::CMD_INSERT, 8'h77, 16'h0000, 5'd31, 1'b0, 1'b0, R_OK},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b0, R_OK},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b0, R_OK},
    '{htd_pkg::CMD_INSERT, 8'hFF, 16'hFFFF, 5'd16, 1'b1, 1'b0, R_OK},
    '{htd_pkg::CMD_INSERT, 8'h81, 16'h8000, 5'd16, 1'b0, 1'b0, R_OK},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, R_OK},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, R_OK},
    '{htd_pkg::CMD_INSERT, 8'h42, 16'h0001, 5'd17, 1'b0, 1'b0, R_OK},
    '{htd_pkg::CMD_INSERT, 8'h99, 16'h0000, 5'd16, 1'b0, 1'b1, R_DUP},
    '{htd_pkg::CMD_CLEAR,  8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, R_OK},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, R_MISS},
    '{htd_pkg::CMD_INSERT, 8'h11, 16'h0005, 5'd3,  1'b0, 1'b1, R_OK},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b1, R_OK},
    '{htd_pkg::CMD_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b1, R_MISS}
  };

  huffman_tree_decoder #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .MAX_NODES    (MAX_NODES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .symbol_in_i    (symbol_in_i),
    .code_bits_i    (code_bits_i),
    .code_len_i     (code_len_i),
    .code_bit_i     (code_bit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_valid_o (symbol_valid_o),
    .symbol_out_o   (symbol_out_o),
    .status_o       (status_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // empty table: root only, walk back at the root
  function automatic void tree_clear();
    for (int unsigned n = 0; n < MAX_NODES; n++) begin
      tree_left[n]  = 0;
      tree_right[n] = 0;
      tree_sym[n]   = 8'h00;
      tree_leaf[n]  = 1'b0;
    end
    tree_used = 1;
    walk_node = 0;
  endfunction

  // walk a codeword from the root, allocating children, mark the leaf
  function automatic htd_pkg::status_e tree_insert(logic [7:0] s, logic [15:0] b,
                                                   logic [4:0] l);
    int unsigned n;
    int unsigned cur;
    int unsigned nxt;
    int          p;
    n = (l > MAX_CODE_LEN) ? MAX_CODE_LEN : l;
    if (n == 0) return htd_pkg::ST_OK;
    cur = 0;
    for (p = int'(n) - 1; p >= 0; p--) begin
      nxt = b[p] ? tree_right[cur] : tree_left[cur];
      if (nxt == 0) begin
        if (tree_used >= MAX_NODES) return htd_pkg::ST_FULL;
        tree_left[tree_used]  = 0;
        tree_right[tree_used] = 0;
        tree_sym[tree_used]   = 8'h00;
        tree_leaf[tree_used]  = 1'b0;
        if (b[p]) tree_right[cur] = tree_used;
        else tree_left[cur] = tree_used;
        nxt = tree_used;
        tree_used++;
      end
      cur = nxt;
    end
    if (tree_leaf[cur]) return htd_pkg::ST_DUP;
    tree_leaf[cur] = 1'b1;
    tree_sym[cur]  = s;
    return htd_pkg::ST_OK;
  endfunction

  // result of one command, updating the model state
  function automatic htd_pkg::res_t tree_step(htd_pkg::cmd_e c, logic [7:0] s,
                                              logic [15:0] b, logic [4:0] l, logic bt);
    htd_pkg::res_t r;
    int unsigned   nxt;
    r = R_OK;
    case (c)
      htd_pkg::CMD_INSERT: begin
        r.status = tree_insert(s, b, l);
        if (r.status != htd_pkg::ST_OK) walk_node = 0;
      end
      htd_pkg::CMD_DECODE: begin
        nxt = bt ? tree_right[walk_node] : tree_left[walk_node];
        if (nxt == 0) begin
          r.status  = htd_pkg::ST_MISSING;
          walk_node = 0;
        end else if (tree_leaf[nxt]) begin
          r.sym_valid = 1'b1;
          r.sym       = tree_sym[nxt];
          walk_node   = 0;
        end else begin
          walk_node = nxt;
        end
      end
      htd_pkg::CMD_CLEAR: tree_clear();
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // one input transfer, then log its expected result
  task automatic push_command(htd_pkg::cmd_e c, logic [7:0] s, logic [15:0] b,
                              logic [4:0] l, logic bt, bit typed, htd_pkg::res_t want);
    int unsigned   gap;
    htd_pkg::res_t got;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    symbol_in_i <= s;
    code_bits_i <= b;
    code_len_i  <= l;
    code_bit_i  <= bt;
    do @(posedge clk_i); while (!in_ready_o);
    got = tree_step(c, s, b, l, bt);
    due_results.push_back(typed ? want : got);
    if (c != htd_pkg::CMD_NOP) n_items++;
  endtask

  task automatic push_plain(htd_pkg::cmd_e c, logic [7:0] s, logic [15:0] b,
                            logic [4:0] l, logic bt);
    push_command(c, s, b, l, bt, 1'b0, R_OK);
  endtask

  // sender holds off until every result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  task automatic clear_table();
    push_plain(htd_pkg::CMD_CLEAR, 8'($urandom), 16'($urandom), 5'($urandom),
               1'($urandom));
    known_codes.delete();
  endtask

  // random codeword, mostly short, sometimes over-long or empty
  task automatic add_code(int unsigned len);
    codeword_t cw;
    cw.bits = 16'($urandom);
    cw.len  = 5'(len);
    push_plain(htd_pkg::CMD_INSERT, 8'($urandom), cw.bits, cw.len, 1'($urandom));
    known_codes.push_back(cw);
  endtask

  task automatic add_random_code();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 39);
    if (pick == 0) len = 0;
    else if (pick < 3) len = $urandom_range(17, 31);
    else if (pick < 7) len = $urandom_range(9, 16);
    else len = $urandom_range(1, 8);
    add_code(len);
  endtask

  // feed a codeword bit by bit, with the odd stray bit, insert or idle command
  task automatic decode_code(codeword_t cw);
    int          n;
    int          k;
    logic        bt;
    n = (cw.len > MAX_CODE_LEN) ? MAX_CODE_LEN : cw.len;
    for (k = n - 1; k >= 0; k--) begin
      bt = cw.bits[k];
      if ($urandom_range(0, 15) == 0) bt = 1'($urandom);
      if ($urandom_range(0, 39) == 0) add_random_code();
      if ($urandom_range(0, 59) == 0)
        push_plain(htd_pkg::CMD_NOP, 8'($urandom), 16'($urandom), 5'($urandom),
                   1'($urandom));
      push_plain(htd_pkg::CMD_DECODE, 8'($urandom), 16'($urandom), 5'($urandom), bt);
    end
  endtask

  task automatic decode_some(int unsigned count);
    codeword_t cw;
    repeat (count) begin
      if (known_codes.size() == 0) begin
        push_plain(htd_pkg::CMD_DECODE, 8'($urandom), 16'($urandom), 5'($urandom),
                   1'($urandom));
      end else begin
        cw = known_codes[$urandom_range(0, known_codes.size() - 1)];
        decode_code(cw);
      end
    end
  endtask

  // long codewords until the table overflows
  task automatic fill_table();
    clear_table();
    while (tree_used < MAX_NODES) add_code(16);
    repeat (3) add_code(16);
    decode_some(10);
  endtask

  // main sequence
  initial begin
    int unsigned phase;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cmd_i       <= htd_pkg::CMD_NOP;
    symbol_in_i <= '0;
    code_bits_i <= '0;
    code_len_i  <= '0;
    code_bit_i  <= 1'b0;
    steady      = 1'b0;
    mismatches  = 0;
    n_items     = 0;
    tree_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      push_command(directed[i].cmd, directed[i].sym, directed[i].bits, directed[i].len,
                   directed[i].bit_v, directed[i].typed, directed[i].want);
    drain_results();

    // random phases: build a code set, decode it, sometimes overflow the table
    phase = 0;
    while (n_items < RANDOM_ITEMS + 25) begin
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 1 || $urandom_range(0, 9) == 0) begin
        fill_table();
      end else begin
        if ($urandom_range(0, 2) == 0) clear_table();
        repeat ($urandom_range(2, 12)) add_random_code();
        decode_some($urandom_range(5, 20));
      end
      if ($urandom_range(0, 3) == 0) drain_results();
      phase++;
    end

    // let the last results come back
    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);
    if (due_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("ran %0d commands in %0d phases: %0d symbols decoded", n_items, phase, n_symbols);
    $display("error results seen: %0d duplicate, %0d table full, %0d missing child",
             n_dup, n_full, n_missing);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side, stalls drawn per transfer
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    htd_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_o == htd_pkg::ST_DUP) n_dup++;
      if (status_o == htd_pkg::ST_FULL) n_full++;
      if (status_o == htd_pkg::ST_MISSING) n_missing++;
      if (symbol_valid_o) n_symbols++;
      if (due_results.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (symbol_valid_o !== want.sym_valid)
          flag_mismatch($sformatf("symbol_valid %b, expected %b", symbol_valid_o,
                                  want.sym_valid));
        if (symbol_out_o !== want.sym)
          flag_mismatch($sformatf("symbol_out %02h, expected %02h", symbol_out_o, want.sym));
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/htd_pkg.sv
rtl/htd_node_mem.sv
rtl/htd_res_q.sv
rtl/htd_ctrl.sv
rtl/huffman_tree_decoder.sv
test/huffman_tree_decoder_tb.sv
